// ===== sv/c3m_pkg.sv =====
`timescale 1ns / 1ps

package c3m_pkg;

  localparam logic [1:0] OP_PIX  = 2'd0;
  localparam logic [1:0] OP_WT   = 2'd1;
  localparam logic [1:0] OP_BIAS = 2'd2;

  localparam int NCH       = 4;
  localparam int TAPS      = 9;
  localparam int NPROD     = NCH * TAPS;
  localparam int OUT_DEPTH = 8;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic       emit;
    logic [7:0] row;
    logic [7:0] col;
    logic       fend;
  } c3m_tag_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         idx;
    logic signed [15:0] val;
    logic [63:0]        pix;
    c3m_tag_t           tag;
  } c3m_item_t;

  typedef struct packed {
    logic [NCH-1:0][31:0] res;
    logic [7:0]           row;
    logic [7:0]           col;
    logic                 fend;
  } c3m_res_t;

endpackage

// ===== sv/conv3x3_multichannel_window_mac.sv =====
`timescale 1ns / 1ps

// 3x3 convolution over a zero-padded image sent in raster order, one padded pixel of
// four Q8.8 channels per beat, with weight and bias loads taken in the same stream and
// applied in order. One beat is accepted every cycle while full is low, and the rate
// holds at one beat per cycle while results are popped as fast as they come, the
// eight-entry output queue and its credit count setting how far the output side may
// fall behind before full rises. The line buffer is one memory with one write and two
// reads per cycle, and the 144 products of a pixel are formed in parallel and summed
// over a registered tree.
module conv3x3_multichannel_window_mac import c3m_pkg::*; #(
  parameter int IMG_W  = 256,
  parameter int IMG_H  = 256,
  parameter int IN_CH  = 4,
  parameter int OUT_CH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op,
  input  logic [7:0]         load_index,
  input  logic signed [15:0] load_value,
  input  logic signed [15:0] pix_c0,
  input  logic signed [15:0] pix_c1,
  input  logic signed [15:0] pix_c2,
  input  logic signed [15:0] pix_c3,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] res_c0,
  output logic signed [31:0] res_c1,
  output logic signed [31:0] res_c2,
  output logic signed [31:0] res_c3,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic               frame_end
);

  localparam int CW = $clog2(IMG_W + 2);
  localparam int MW = $bits(c3m_item_t) + 2 + CW;

  c3m_item_t      f_item;
  logic [1:0]     f_r3;
  logic [CW-1:0]  f_col;
  logic           f_wr;
  logic [MW-1:0]  m_data;
  c3m_item_t      m_item;
  logic [1:0]     m_r3;
  logic [CW-1:0]  m_col;
  logic           m_empty;
  logic           m_rd;
  logic           o_wr;
  c3m_res_t       o_res;
  c3m_res_t       o_head;
  logic [OCW-1:0] o_count;

  c3m_front #(.IMG_W(IMG_W), .IMG_H(IMG_H)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .q_full     (full),
    .op         (op),
    .load_index (load_index),
    .load_value (load_value),
    .pix_c0     (pix_c0),
    .pix_c1     (pix_c1),
    .pix_c2     (pix_c2),
    .pix_c3     (pix_c3),
    .q_wr       (f_wr),
    .q_item     (f_item),
    .q_r3       (f_r3),
    .q_col      (f_col)
  );

  c3m_fifo #(.W(MW), .DEPTH(4)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_wr),
    .wdata ({f_item, f_r3, f_col}),
    .full  (full),
    .rd    (m_rd),
    .rdata (m_data),
    .empty (m_empty),
    .count ()
  );

  assign {m_item, m_r3, m_col} = m_data;

  c3m_back #(.IMG_W(IMG_W), .IN_CH(IN_CH), .OUT_CH(OUT_CH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!m_empty),
    .q_item  (m_item),
    .q_r3    (m_r3),
    .q_col   (m_col),
    .q_rd    (m_rd),
    .o_count (o_count),
    .o_wr    (o_wr),
    .o_res   (o_res)
  );

  c3m_fifo #(.W($bits(c3m_res_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .wr    (o_wr),
    .wdata (o_res),
    .full  (),
    .rd    (pop),
    .rdata (o_head),
    .empty (empty),
    .count (o_count)
  );

  assign res_c0    = o_head.res[0];
  assign res_c1    = o_head.res[1];
  assign res_c2    = o_head.res[2];
  assign res_c3    = o_head.res[3];
  assign out_row   = o_head.row;
  assign out_col   = o_head.col;
  assign frame_end = o_head.fend;

endmodule

// ===== sv/c3m_fifo.sv =====
`timescale 1ns / 1ps

module c3m_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr,
  input  logic [W-1:0]                     wdata,
  output logic                             full,
  input  logic                             rd,
  output logic [W-1:0]                     rdata,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CNTW-1:0] fill;
  logic            wr_en;
  logic            rd_en;

  assign full  = (fill == CNTW'(DEPTH));
  assign empty = (fill == '0);
  assign count = fill;
  assign wr_en = wr && !full;
  assign rd_en = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + PW'(1);
      end
      if (rd_en) begin
        rptr <= rptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNTW'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== sv/c3m_front.sv =====
`timescale 1ns / 1ps

module c3m_front import c3m_pkg::*; #(
  parameter int IMG_W = 256,
  parameter int IMG_H = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            q_full,
  input  logic [1:0]                      op,
  input  logic [7:0]                      load_index,
  input  logic signed [15:0]              load_value,
  input  logic signed [15:0]              pix_c0,
  input  logic signed [15:0]              pix_c1,
  input  logic signed [15:0]              pix_c2,
  input  logic signed [15:0]              pix_c3,
  output logic                            q_wr,
  output c3m_item_t                       q_item,
  output logic [1:0]                      q_r3,
  output logic [$clog2(IMG_W+2)-1:0]      q_col
);

  localparam int PAD_W = IMG_W + 2;
  localparam int PAD_H = IMG_H + 2;
  localparam int CW    = $clog2(PAD_W);
  localparam int RW    = $clog2(PAD_H);

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [1:0]    r3;
  logic          accept;
  logic          keep;
  logic [15:0]   row_off;
  logic [15:0]   col_off;

  assign accept  = push && !q_full;
  assign row_off = 16'(row) - 16'd2;
  assign col_off = 16'(col) - 16'd2;

  always_comb begin
    unique case (op) inside
      OP_PIX, OP_WT, OP_BIAS: keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  assign q_wr            = accept && keep;
  assign q_item.kind     = op;
  assign q_item.idx      = load_index;
  assign q_item.val      = load_value;
  assign q_item.pix      = {pix_c3, pix_c2, pix_c1, pix_c0};
  assign q_item.tag.emit = (row >= RW'(2)) && (col >= CW'(2));
  assign q_item.tag.row  = row_off[7:0];
  assign q_item.tag.col  = col_off[7:0];
  assign q_item.tag.fend = (row == RW'(PAD_H - 1)) && (col == CW'(PAD_W - 1));
  assign q_r3            = r3;
  assign q_col           = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      r3  <= '0;
    end else if (accept && op == OP_PIX) begin
      if (col == CW'(PAD_W - 1)) begin
        col <= '0;
        if (row == RW'(PAD_H - 1)) begin
          row <= '0;
          r3  <= '0;
        end else begin
          row <= row + RW'(1);
          r3  <= (r3 == 2'd2) ? 2'd0 : r3 + 2'd1;
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

// ===== sv/c3m_back.sv =====
`timescale 1ns / 1ps

module c3m_back import c3m_pkg::*; #(
  parameter int IMG_W  = 256,
  parameter int IN_CH  = 4,
  parameter int OUT_CH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  c3m_item_t                       q_item,
  input  logic [1:0]                      q_r3,
  input  logic [$clog2(IMG_W+2)-1:0]      q_col,
  output logic                            q_rd,
  input  logic [OCW-1:0]                  o_count,
  output logic                            o_wr,
  output c3m_res_t                        o_res
);

  localparam int PAD_W  = IMG_W + 2;
  localparam int LDEPTH = 3 * PAD_W;
  localparam int AW     = $clog2(LDEPTH);
  localparam int N_IN   = (IN_CH < NCH) ? IN_CH : NCH;
  localparam int N_OUT  = (OUT_CH < NCH) ? OUT_CH : NCH;

  logic [63:0]        line [LDEPTH];
  logic [63:0]        rd0;
  logic [63:0]        rd1;
  logic [AW-1:0]      aw;
  logic [AW-1:0]      a0;
  logic [AW-1:0]      a1;
  logic [1:0]         r3p1;
  logic [1:0]         r3p2;
  logic [OCW-1:0]     inflight;
  logic               issue;
  logic               inc;

  c3m_item_t          s1;
  logic               v1;
  logic               pix1;
  logic               wt1;
  logic               bs1;
  logic [63:0]        cur [3];
  logic [63:0]        win [6];
  logic signed [15:0] tapv [NCH][TAPS];
  logic signed [15:0] wt [NCH][NPROD];
  logic signed [15:0] bias [NCH];
  logic signed [31:0] mul [NCH][NPROD];

  logic signed [31:0] p2 [NCH][NPROD];
  logic signed [33:0] q3 [NCH][9];
  logic signed [35:0] r4 [NCH][3];
  logic signed [37:0] t5 [NCH];
  logic signed [15:0] b2 [NCH];
  logic signed [15:0] b3 [NCH];
  logic signed [15:0] b4 [NCH];
  c3m_tag_t           t2, t3, t4, g5;
  logic               v2, v3, v4, v5;

  // Credits keep every result that is issued sure of a place in the output queue.
  assign issue = q_valid &&
                 (({1'b0, inflight} + {1'b0, o_count}) < (OCW + 1)'(OUT_DEPTH));
  assign q_rd  = issue;
  assign inc   = issue && q_item.kind == OP_PIX && q_item.tag.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + OCW'(inc) - OCW'(o_wr);
    end
  end

  assign r3p1 = (q_r3 == 2'd2) ? 2'd0 : q_r3 + 2'd1;
  assign r3p2 = (q_r3 == 2'd0) ? 2'd2 : q_r3 - 2'd1;
  assign aw   = AW'(q_r3) * AW'(PAD_W) + AW'(q_col);
  assign a0   = AW'(r3p1) * AW'(PAD_W) + AW'(q_col);
  assign a1   = AW'(r3p2) * AW'(PAD_W) + AW'(q_col);

  always_ff @(posedge clk) begin
    if (issue && q_item.kind == OP_PIX) begin
      line[aw] <= q_item.pix;
    end
    rd0 <= line[a0];
    rd1 <= line[a1];
    s1  <= q_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
    end
  end

  assign pix1   = v1 && s1.kind == OP_PIX;
  assign wt1    = v1 && s1.kind == OP_WT;
  assign bs1    = v1 && s1.kind == OP_BIAS;
  assign cur[0] = rd0;
  assign cur[1] = rd1;
  assign cur[2] = s1.pix;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      for (int ky = 0; ky < 3; ky++) begin
        for (int kx = 0; kx < 3; kx++) begin
          if (kx == 2) begin
            tapv[i][ky*3+kx] = cur[ky][16*i +: 16];
          end else begin
            tapv[i][ky*3+kx] = win[kx*3+ky][16*i +: 16];
          end
        end
      end
    end
  end

  always_comb begin
    for (int o = 0; o < NCH; o++) begin
      for (int i = 0; i < NCH; i++) begin
        for (int t = 0; t < TAPS; t++) begin
          mul[o][i*TAPS+t] = tapv[i][t] * wt[o][i*TAPS+t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else if (pix1) begin
      for (int k = 0; k < 3; k++) begin
        win[k]   <= win[3+k];
        win[3+k] <= cur[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wt1) begin
      for (int o = 0; o < NCH; o++) begin
        for (int i = 0; i < NCH; i++) begin
          for (int t = 0; t < TAPS; t++) begin
            if (o < N_OUT && i < N_IN && int'(s1.idx) == (i*TAPS+t)*OUT_CH+o) begin
              wt[o][i*TAPS+t] <= s1.val;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < NCH; o++) begin
        bias[o] <= '0;
      end
    end else if (bs1) begin
      for (int o = 0; o < N_OUT; o++) begin
        if (int'(s1.idx) == o) begin
          bias[o] <= s1.val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int o = 0; o < NCH; o++) begin
      for (int i = 0; i < NCH; i++) begin
        for (int t = 0; t < TAPS; t++) begin
          if (o < N_OUT && i < N_IN) begin
            p2[o][i*TAPS+t] <= mul[o][i*TAPS+t];
          end else begin
            p2[o][i*TAPS+t] <= '0;
          end
        end
      end
      b2[o] <= bias[o];
      b3[o] <= b2[o];
      b4[o] <= b3[o];
      for (int g = 0; g < 9; g++) begin
        q3[o][g] <= 34'(p2[o][4*g]) + 34'(p2[o][4*g+1]) +
                    34'(p2[o][4*g+2]) + 34'(p2[o][4*g+3]);
      end
      for (int h = 0; h < 3; h++) begin
        r4[o][h] <= 36'(q3[o][3*h]) + 36'(q3[o][3*h+1]) + 36'(q3[o][3*h+2]);
      end
      t5[o] <= 38'(r4[o][0]) + 38'(r4[o][1]) + 38'(r4[o][2]) + (38'(b4[o]) <<< 8);
    end
    t2 <= s1.tag;
    t3 <= t2;
    t4 <= t3;
    g5 <= t4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v2 <= pix1 && s1.tag.emit;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    for (int o = 0; o < NCH; o++) begin
      if (t5[o][37:31] == '0 || t5[o][37:31] == '1) begin
        o_res.res[o] = t5[o][31:0];
      end else if (t5[o][37]) begin
        o_res.res[o] = SAT_MIN;
      end else begin
        o_res.res[o] = SAT_MAX;
      end
    end
  end

  assign o_res.row  = g5.row;
  assign o_res.col  = g5.col;
  assign o_res.fend = g5.fend;
  assign o_wr       = v5;

endmodule
